@@ hw/rtl/bis_pkg.sv @@
// Shared constants and types for the blocked index-sequential search block.
package bis_pkg;

   localparam int MAX_ITEMS   = 256;
   localparam int MAX_BLOCKS  = 16;

   localparam int ITEM_AW     = $clog2(MAX_ITEMS);
   localparam int BLOCK_AW    = $clog2(MAX_BLOCKS);

   localparam int CMD_W       = 2;
   localparam int SLOT_W      = 8;
   localparam int VALUE_W     = 32;
   localparam int POS_W       = 9;
   localparam int CMP_W       = 9;

   localparam int ITEM_CNT_W  = 9;
   localparam int BLOCK_CNT_W = 5;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 9;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_ITEM_COUNT  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_COUNT = 1'b1;

   // Command codes of an input word.
   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE_ITEM  = 2'd0,
      CMD_WRITE_BLOCK = 2'd1,
      CMD_SEARCH      = 2'd2
   } cmd_type;

endpackage

@@ hw/rtl/bis_req_if.sv @@
// Input channel: command words with valid/ready handshake.
interface bis_req_if;
   import bis_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [CMD_W-1:0]          command;
   logic [SLOT_W-1:0]         slot;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output command, output slot, output value, input ready);
   modport sink   (input valid, input command, input slot, input value, output ready);
endinterface

@@ hw/rtl/bis_rsp_if.sv @@
// Result channel: search results with valid/ready handshake.
interface bis_rsp_if;
   import bis_pkg::*;

   logic             valid;
   logic             ready;
   logic             found;
   logic [POS_W-1:0] position;
   logic [CMP_W-1:0] compare_count;

   modport source (output valid, output found, output position, output compare_count,
                   input ready);
   modport sink   (input valid, input found, input position, input compare_count,
                   output ready);
endinterface

@@ hw/rtl/blocked_index_sequential_search.sv @@
// Blocked index-sequential search: item memory, block-maximum index and search sequencer.
//
// Write words (item or block maximum) produce no result. A search takes its word, runs a
// bit-serial divider that forms len = item_count / block_count, scans B index entries
// (1..block_count) and then T items of the chosen block (0..len), and passes its result
// to the output register. The scans make one compare per cycle against the index memory
// and then the item memory, each read through a single registered port. The result sits
// in an output register, so write words are taken while it waits; the next search finishes
// only once that register is free. No word is taken while a search is in progress.
// Memories are not cleared by reset.
module blocked_index_sequential_search (
   input  logic                          clock,
   input  logic                          reset,
   bis_req_if.sink                       req,
   bis_rsp_if.source                     rsp,
   input  logic                          csr_we,
   input  logic [bis_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bis_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import bis_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_IDX,
      S_ITEM,
      S_OUT
   } state_type;

   localparam int DIV_STEPS = ITEM_CNT_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // Memories
   logic [VALUE_W-1:0] item_mem  [MAX_ITEMS];
   logic [VALUE_W-1:0] block_mem [MAX_BLOCKS];
   logic [VALUE_W-1:0] item_rd_ff;
   logic [VALUE_W-1:0] block_rd_ff;
   logic [ITEM_AW-1:0]  item_raddr;
   logic [BLOCK_AW-1:0] block_raddr;

   // Control and datapath registers
   state_type               state_ff, state_in;
   logic [ITEM_CNT_W-1:0]   item_count_ff;
   logic [BLOCK_CNT_W-1:0]  block_count_ff;
   logic [VALUE_W-1:0]      key_ff, key_in;
   logic [BLOCK_CNT_W-1:0]  k_ff, k_in;
   logic [BLOCK_CNT_W-1:0]  div_rem_ff, div_rem_in;
   logic [ITEM_CNT_W-1:0]   div_q_ff, div_q_in;
   logic [DIV_CNT_W-1:0]    div_cnt_ff, div_cnt_in;
   logic [BLOCK_CNT_W-1:0]  blk_idx_ff, blk_idx_in;
   logic [ITEM_CNT_W-1:0]   base_ff, base_in;
   logic [ITEM_CNT_W-1:0]   t_ff, t_in;
   logic                    res_found_ff, res_found_in;
   logic [POS_W-1:0]        res_pos_ff, res_pos_in;
   logic [CMP_W-1:0]        res_cmp_ff, res_cmp_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_found_ff, rsp_found_in;
   logic [POS_W-1:0]        rsp_pos_ff, rsp_pos_in;
   logic [CMP_W-1:0]        rsp_cmp_ff, rsp_cmp_in;

   logic                    req_fire;
   logic [ITEM_CNT_W-1:0]   n_clamped;
   logic [BLOCK_CNT_W-1:0]  k_clamped;
   logic [BLOCK_CNT_W:0]    rem_shift;
   logic [BLOCK_CNT_W:0]    rem_diff;
   logic [ITEM_CNT_W-1:0]   item_addr_sum;
   logic [ITEM_CNT_W-1:0]   len;

   assign req.ready     = (state_ff == S_IDLE);
   assign req_fire      = req.valid && req.ready;
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.found     = rsp_found_ff;
   assign rsp.position  = rsp_pos_ff;
   assign rsp.compare_count = rsp_cmp_ff;

   assign len = div_q_ff;

   // Saturate the configuration into its legal range
   always_comb begin
      if (item_count_ff == '0) begin
         n_clamped = ITEM_CNT_W'(1);
      end else if (item_count_ff > ITEM_CNT_W'(MAX_ITEMS)) begin
         n_clamped = ITEM_CNT_W'(MAX_ITEMS);
      end else begin
         n_clamped = item_count_ff;
      end
      if (block_count_ff == '0) begin
         k_clamped = BLOCK_CNT_W'(1);
      end else if (block_count_ff > BLOCK_CNT_W'(MAX_BLOCKS)) begin
         k_clamped = BLOCK_CNT_W'(MAX_BLOCKS);
      end else begin
         k_clamped = block_count_ff;
      end
   end

   // One divider step: shift in the next dividend bit, subtract if it fits
   assign rem_shift = {div_rem_ff, div_q_ff[ITEM_CNT_W-1]};
   assign rem_diff  = rem_shift - {1'b0, k_ff};

   // Sequencer next state
   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      k_in         = k_ff;
      div_rem_in   = div_rem_ff;
      div_q_in     = div_q_ff;
      div_cnt_in   = div_cnt_ff;
      blk_idx_in   = blk_idx_ff;
      base_in      = base_ff;
      t_in         = t_ff;
      res_found_in = res_found_ff;
      res_pos_in   = res_pos_ff;
      res_cmp_in   = res_cmp_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_cmp_in   = rsp_cmp_ff;

      // Drop the result once taken
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire && req.command == CMD_SEARCH) begin
               key_in     = req.value;
               k_in       = k_clamped;
               div_rem_in = '0;
               div_q_in   = n_clamped;
               div_cnt_in = '0;
               blk_idx_in = '0;
               base_in    = '0;
               t_in       = '0;
               state_in   = S_DIV;
            end
         end
         S_DIV: begin
            if (rem_shift >= {1'b0, k_ff}) begin
               div_rem_in = rem_diff[BLOCK_CNT_W-1:0];
               div_q_in   = {div_q_ff[ITEM_CNT_W-2:0], 1'b1};
            end else begin
               div_rem_in = rem_shift[BLOCK_CNT_W-1:0];
               div_q_in   = {div_q_ff[ITEM_CNT_W-2:0], 1'b0};
            end
            div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
            if (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = S_IDX;
            end
         end
         S_IDX: begin
            if ($signed(block_rd_ff) >= $signed(key_ff)) begin
               if (len == '0) begin
                  res_found_in = 1'b0;
                  res_pos_in   = '0;
                  res_cmp_in   = '0;
                  state_in     = S_OUT;
               end else begin
                  t_in     = '0;
                  state_in = S_ITEM;
               end
            end else if (blk_idx_ff + BLOCK_CNT_W'(1) == k_ff) begin
               res_found_in = 1'b0;
               res_pos_in   = '0;
               res_cmp_in   = '0;
               state_in     = S_OUT;
            end else begin
               blk_idx_in = blk_idx_ff + BLOCK_CNT_W'(1);
               base_in    = base_ff + len;
            end
         end
         S_ITEM: begin
            if (item_rd_ff == key_ff) begin
               res_found_in = 1'b1;
               res_pos_in   = POS_W'(base_ff + t_ff + ITEM_CNT_W'(1));
               res_cmp_in   = CMP_W'(t_ff + ITEM_CNT_W'(1))
                            + CMP_W'(blk_idx_ff) + CMP_W'(1);
               state_in     = S_OUT;
            end else if (t_ff + ITEM_CNT_W'(1) == len) begin
               res_found_in = 1'b0;
               res_pos_in   = '0;
               res_cmp_in   = '0;
               state_in     = S_OUT;
            end else begin
               t_in = t_ff + ITEM_CNT_W'(1);
            end
         end
         S_OUT: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = res_found_ff;
               rsp_pos_in   = res_pos_ff;
               rsp_cmp_in   = res_cmp_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Read addresses follow the next scan position so data lines up with the registers
   assign item_addr_sum = base_in + t_in;
   assign item_raddr    = item_addr_sum[ITEM_AW-1:0];
   assign block_raddr   = blk_idx_in[BLOCK_AW-1:0];

   // State, configuration and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         item_count_ff  <= ITEM_CNT_W'(MAX_ITEMS);
         block_count_ff <= BLOCK_CNT_W'(MAX_BLOCKS);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_ITEM_COUNT:  item_count_ff  <= csr_wdata[ITEM_CNT_W-1:0];
               CSR_BLOCK_COUNT: block_count_ff <= csr_wdata[BLOCK_CNT_W-1:0];
               default: ;
            endcase
         end
      end
      key_ff       <= key_in;
      k_ff         <= k_in;
      div_rem_ff   <= div_rem_in;
      div_q_ff     <= div_q_in;
      div_cnt_ff   <= div_cnt_in;
      blk_idx_ff   <= blk_idx_in;
      base_ff      <= base_in;
      t_ff         <= t_in;
      res_found_ff <= res_found_in;
      res_pos_ff   <= res_pos_in;
      res_cmp_ff   <= res_cmp_in;
      rsp_found_ff <= rsp_found_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_cmp_ff   <= rsp_cmp_in;
   end

   // Item memory: write on an item word, one registered read port
   always_ff @(posedge clock) begin
      if (req_fire && req.command == CMD_WRITE_ITEM) begin
         item_mem[req.slot[ITEM_AW-1:0]] <= req.value;
      end
      item_rd_ff <= item_mem[item_raddr];
   end

   // Index memory: write on a block word inside the index range, one registered read port
   always_ff @(posedge clock) begin
      if (req_fire && req.command == CMD_WRITE_BLOCK
          && req.slot < SLOT_W'(MAX_BLOCKS)) begin
         block_mem[req.slot[BLOCK_AW-1:0]] <= req.value;
      end
      block_rd_ff <= block_mem[block_raddr];
   end

`ifndef SYNTHESIS
   // A found result carries a nonzero position and at least two compares
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.found |-> rsp.position != '0 && rsp.compare_count >= CMP_W'(2))
      else $error("found result with empty position or compare count");

   // A miss reports zeros
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.found |-> rsp.position == '0 && rsp.compare_count == '0)
      else $error("miss result with nonzero fields");

   // The index scan never passes the last block
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDX |-> blk_idx_ff < k_ff)
      else $error("index scan beyond block count");

   // The item scan stays inside the block
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ITEM |-> t_ff < len && len != '0)
      else $error("item scan beyond block length");

   // A search word leads straight into the divider
   assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready && req.command == CMD_SEARCH |=> state_ff == S_DIV)
      else $error("search not started");
`endif

endmodule
